@@ rtl/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg: shared types for the swept point-versus-box collision unit
// Geometry is carried at twice the input scale so half sums stay exact.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int IN_W      = 32;
    localparam int SIZE_W    = 31;
    localparam int GEO_W     = 38;
    localparam int MAG_W     = 34;
    localparam int HALF_W    = MAG_W / 2;
    localparam int PP_W      = MAG_W + HALF_W;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int CROSS_LAT = MAG_W + 5;

    typedef logic signed [GEO_W-1:0] t_geo;
    typedef logic [MAG_W-1:0]        t_mag;

    typedef enum logic [2:0] {
        FACE_NONE   = 3'd0,
        FACE_INSIDE = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_BOTTOM = 3'd4,
        FACE_TOP    = 3'd5
    } t_face;

    typedef struct packed {
        logic signed [IN_W-1:0] own_pos_x;
        logic signed [IN_W-1:0] own_pos_y;
        logic signed [IN_W-1:0] own_vel_x;
        logic signed [IN_W-1:0] own_vel_y;
        logic [SIZE_W-1:0]      own_width;
        logic [SIZE_W-1:0]      own_height;
        logic signed [IN_W-1:0] other_pos_x;
        logic signed [IN_W-1:0] other_pos_y;
        logic signed [IN_W-1:0] other_vel_x;
        logic signed [IN_W-1:0] other_vel_y;
        logic [SIZE_W-1:0]      other_width;
        logic [SIZE_W-1:0]      other_height;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic [2:0]             hit_face;
        logic signed [IN_W-1:0] point_x;
        logic signed [IN_W-1:0] point_y;
    } t_out_item;

    typedef struct packed {
        logic ok;
        t_geo num;
        t_geo den;
        t_geo db;
        t_geo b1;
        t_geo lo;
        t_geo hi;
    } t_cross_req;

    typedef struct packed {
        logic hit;
        t_geo t;
    } t_cross_res;

endpackage

@@ rtl/spc_stream_if.sv @@
// ----------------------------------------------------------------------------
// spc_stream_if: valid/ready channel
// Carries one request per accepted handshake.
// ----------------------------------------------------------------------------
interface spc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/spc_cross.sv @@
// ----------------------------------------------------------------------------
// spc_cross: face crossing unit
// Finds b1 +/- |db|*|num|/|den| through a split multiplier and a one bit per
// stage restoring divider, then checks it against the open face bounds.
// ----------------------------------------------------------------------------
module spc_cross
    import spc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cross_req i_req,
    output t_cross_res o_res
);

    typedef struct packed {
        logic ok;
        logic neg;
        t_mag den;
        t_geo b1;
        t_geo lo;
        t_geo hi;
    } t_side;

    t_geo n_num_abs;
    t_geo n_den_abs;
    t_geo n_db_abs;

    t_side           r_s1;
    t_mag            r_a;
    t_mag            r_b;
    t_side           r_s2;
    logic [PP_W-1:0] r_pl;
    logic [PP_W-1:0] r_ph;
    logic [PROD_W-1:0] n_prod;

    t_side r_sd  [0:MAG_W];
    t_mag  r_rem [0:MAG_W];
    t_mag  r_lq  [0:MAG_W];

    t_geo  r_t;
    t_side r_ts;
    t_cross_res r_res;

    always_comb begin
        n_num_abs = i_req.num[GEO_W-1] ? -i_req.num : i_req.num;
        n_den_abs = i_req.den[GEO_W-1] ? -i_req.den : i_req.den;
        n_db_abs  = i_req.db[GEO_W-1]  ? -i_req.db  : i_req.db;
        n_prod    = PROD_W'(r_pl) + (PROD_W'(r_ph) << HALF_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a        <= n_db_abs[MAG_W-1:0];
            r_b        <= n_num_abs[MAG_W-1:0];
            r_s1.ok    <= i_req.ok;
            r_s1.neg   <= i_req.db[GEO_W-1] ^ i_req.num[GEO_W-1] ^ i_req.den[GEO_W-1];
            r_s1.den   <= n_den_abs[MAG_W-1:0];
            r_s1.b1    <= i_req.b1;
            r_s1.lo    <= i_req.lo;
            r_s1.hi    <= i_req.hi;

            r_pl       <= PP_W'(r_a * r_b[HALF_W-1:0]);
            r_ph       <= PP_W'(r_a * r_b[MAG_W-1:HALF_W]);
            r_s2       <= r_s1;

            r_rem[0]   <= n_prod[PROD_W-1:MAG_W];
            r_lq[0]    <= n_prod[MAG_W-1:0];
            r_sd[0]    <= r_s2;
        end
    end

    for (genvar k = 1; k <= MAG_W; k++) begin : g_div
        logic [MAG_W:0] n_r2;
        logic [MAG_W:0] n_diff;
        logic           n_ge;

        always_comb begin
            n_r2   = {r_rem[k-1], r_lq[k-1][MAG_W-1]};
            n_diff = n_r2 - {1'b0, r_sd[k-1].den};
            n_ge   = n_r2 >= {1'b0, r_sd[k-1].den};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[MAG_W-1:0] : n_r2[MAG_W-1:0];
                r_lq[k]  <= {r_lq[k-1][MAG_W-2:0], n_ge};
                r_sd[k]  <= r_sd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t       <= r_sd[MAG_W].neg
                         ? r_sd[MAG_W].b1 - t_geo'({{(GEO_W-MAG_W){1'b0}}, r_lq[MAG_W]})
                         : r_sd[MAG_W].b1 + t_geo'({{(GEO_W-MAG_W){1'b0}}, r_lq[MAG_W]});
            r_ts      <= r_sd[MAG_W];
            r_res.t   <= r_t;
            r_res.hit <= r_ts.ok && (r_t > r_ts.lo) && (r_t < r_ts.hi);
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/swept_point_box_collision_unit.sv @@
// ----------------------------------------------------------------------------
// swept_point_box_collision_unit: swept point versus grown box test
// Tests one pair of moving boxes per request and reports the face crossed.
// ----------------------------------------------------------------------------
// Requests of box pairs enter on i_req and results leave on o_res; both are
// valid/ready channels that move one request per handshake.
// The second box is grown by the half sums of both sizes and the first
// centre is swept back along the relative velocity. The result is a hit
// flag, the face (inside, left, right, bottom, top) and the crossing point,
// or all zero on a miss.
// A new request is taken every cycle unless the receiver stalls; the pipelined
// divider allows this, retiring one quotient bit per stage over 34 stages.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and i_req.ready falls, so nothing is lost or repeated.
// Reset clears all valid bits; results in flight are dropped.
// ----------------------------------------------------------------------------
module swept_point_box_collision_unit
    import spc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    spc_stream_if.sink         i_req,
    spc_stream_if.source       o_res
);

    typedef struct packed {
        logic in_box;
        logic xr;
        logic yt;
        t_geo line_x;
        t_geo line_y;
        t_geo px;
        t_geo py;
    } t_dside;

    localparam t_geo OUT_MAX = t_geo'(64'sd2147483647);
    localparam t_geo OUT_MIN = t_geo'(-64'sd2147483648);

    logic en;
    t_in_item d;

    logic r_v1, r_v2, r_v3, r_vf, r_out_valid;
    logic r_dv [0:CROSS_LAT-1];

    t_geo r1_px, r1_py, r1_cx, r1_cy, r1_sw, r1_sh, r1_vx, r1_vy;
    t_geo r2_px, r2_py, r2_cx, r2_cy, r2_vx, r2_vy;
    t_geo r2_x1, r2_x2, r2_y1, r2_y2, r2_qx, r2_qy;

    t_cross_req r3_xreq, r3_yreq, n_xreq, n_yreq;
    t_dside     r3_side, n_side;
    t_dside     r_dl [0:CROSS_LAT-1];
    t_cross_res xres, yres;

    t_face n_face, r_face;
    t_geo  n_rx, n_ry, r_rx, r_ry;
    t_geo  n_hx, n_hy;
    t_out_item r_out;

    logic xl, xr, yb, yt, crl, crr, crb, crt;

    assign en          = !r_out_valid || o_res.ready;
    assign i_req.ready = en;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign d           = i_req.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_vf        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CROSS_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_v1        <= i_req.valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_dv[0]     <= r_v3;
            for (int i = 1; i < CROSS_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_vf        <= r_dv[CROSS_LAT-1];
            r_out_valid <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px <= t_geo'({{(GEO_W-IN_W-1){d.own_pos_x[IN_W-1]}}, d.own_pos_x, 1'b0});
            r1_py <= t_geo'({{(GEO_W-IN_W-1){d.own_pos_y[IN_W-1]}}, d.own_pos_y, 1'b0});
            r1_cx <= t_geo'({{(GEO_W-IN_W-1){d.other_pos_x[IN_W-1]}}, d.other_pos_x, 1'b0});
            r1_cy <= t_geo'({{(GEO_W-IN_W-1){d.other_pos_y[IN_W-1]}}, d.other_pos_y, 1'b0});
            r1_sw <= t_geo'({{(GEO_W-SIZE_W){1'b0}}, d.own_width})
                   + t_geo'({{(GEO_W-SIZE_W){1'b0}}, d.other_width});
            r1_sh <= t_geo'({{(GEO_W-SIZE_W){1'b0}}, d.own_height})
                   + t_geo'({{(GEO_W-SIZE_W){1'b0}}, d.other_height});
            r1_vx <= (t_geo'(d.other_vel_x) - t_geo'(d.own_vel_x)) <<< 1;
            r1_vy <= (t_geo'(d.other_vel_y) - t_geo'(d.own_vel_y)) <<< 1;

            r2_px <= r1_px;
            r2_py <= r1_py;
            r2_cx <= r1_cx;
            r2_cy <= r1_cy;
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_x1 <= r1_cx - r1_sw;
            r2_x2 <= r1_cx + r1_sw;
            r2_y1 <= r1_cy - r1_sh;
            r2_y2 <= r1_cy + r1_sh;
            r2_qx <= r1_px - r1_vx;
            r2_qy <= r1_py - r1_vy;

            r3_xreq <= n_xreq;
            r3_yreq <= n_yreq;
            r3_side <= n_side;

            r_dl[0] <= r3_side;
            for (int i = 1; i < CROSS_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end

            r_face <= n_face;
            r_rx   <= n_rx;
            r_ry   <= n_ry;

            r_out.hit      <= (r_face != FACE_NONE);
            r_out.hit_face <= 3'(r_face);
            r_out.point_x  <= (r_face == FACE_NONE) ? '0 : n_hx[IN_W-1:0];
            r_out.point_y  <= (r_face == FACE_NONE) ? '0 : n_hy[IN_W-1:0];
        end
    end

    always_comb begin
        xl  = r2_px < r2_cx;
        xr  = r2_px > r2_cx;
        yb  = r2_py < r2_cy;
        yt  = r2_py > r2_cy;
        crl = !((r2_px < r2_x1 && r2_qx < r2_x1) || (r2_px > r2_x1 && r2_qx > r2_x1));
        crr = !((r2_px < r2_x2 && r2_qx < r2_x2) || (r2_px > r2_x2 && r2_qx > r2_x2));
        crb = !((r2_py < r2_y1 && r2_qy < r2_y1) || (r2_py > r2_y1 && r2_qy > r2_y1));
        crt = !((r2_py < r2_y2 && r2_qy < r2_y2) || (r2_py > r2_y2 && r2_qy > r2_y2));

        n_xreq.ok  = (r2_vx != '0) && ((xl && crl) || (!xl && xr && crr));
        n_xreq.num = xl ? r2_px - r2_x1 : r2_px - r2_x2;
        n_xreq.den = r2_vx;
        n_xreq.db  = -r2_vy;
        n_xreq.b1  = r2_py;
        n_xreq.lo  = r2_y1;
        n_xreq.hi  = r2_y2;

        n_yreq.ok  = (r2_vy != '0) && ((yb && crb) || (!yb && yt && crt));
        n_yreq.num = yb ? r2_py - r2_y1 : r2_py - r2_y2;
        n_yreq.den = r2_vy;
        n_yreq.db  = -r2_vx;
        n_yreq.b1  = r2_px;
        n_yreq.lo  = r2_x1;
        n_yreq.hi  = r2_x2;

        n_side.in_box = r2_px > r2_x1 && r2_px < r2_x2 && r2_py > r2_y1 && r2_py < r2_y2;
        n_side.xr     = !xl;
        n_side.yt     = !yb;
        n_side.line_x = xl ? r2_x1 : r2_x2;
        n_side.line_y = yb ? r2_y1 : r2_y2;
        n_side.px     = r2_px;
        n_side.py     = r2_py;
    end

    spc_cross u_cross_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (r3_xreq),
        .o_res (xres)
    );

    spc_cross u_cross_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (r3_yreq),
        .o_res (yres)
    );

    always_comb begin
        priority if (r_dl[CROSS_LAT-1].in_box) begin
            n_face = FACE_INSIDE;
            n_rx   = r_dl[CROSS_LAT-1].px;
            n_ry   = r_dl[CROSS_LAT-1].py;
        end else if (xres.hit) begin
            n_face = r_dl[CROSS_LAT-1].xr ? FACE_RIGHT : FACE_LEFT;
            n_rx   = r_dl[CROSS_LAT-1].line_x;
            n_ry   = xres.t;
        end else if (yres.hit) begin
            n_face = r_dl[CROSS_LAT-1].yt ? FACE_TOP : FACE_BOTTOM;
            n_rx   = yres.t;
            n_ry   = r_dl[CROSS_LAT-1].line_y;
        end else begin
            n_face = FACE_NONE;
            n_rx   = '0;
            n_ry   = '0;
        end
    end

    always_comb begin
        n_hx = r_rx >>> 1;
        n_hy = r_ry >>> 1;
        if (n_hx > OUT_MAX) begin
            n_hx = OUT_MAX;
        end else if (n_hx < OUT_MIN) begin
            n_hx = OUT_MIN;
        end
        if (n_hy > OUT_MAX) begin
            n_hy = OUT_MAX;
        end else if (n_hy < OUT_MIN) begin
            n_hy = OUT_MIN;
        end
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: regression bench for the swept point-versus-box collision unit
// Random and directed box pairs are pushed through the request channel with
// random idle bursts on both sides; each result is checked field by field
// against an in-bench collision predictor.
// ----------------------------------------------------------------------------
module tb
    import spc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 43;
    localparam int LIMIT     = 200000;
    localparam int N_RANDOM  = 630;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spc_stream_if #(.t_payload(t_in_item))  req_if ();
    spc_stream_if #(.t_payload(t_out_item)) res_if ();

    swept_point_box_collision_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in_item  pending_pairs[$];
    t_out_item expected_hits[$];
    int        errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        face_count[6];
    int        cycles = 0;
    bit        calm = 1'b0;
    int        src_gap = 0;
    int        snk_gap = 0;

    function automatic bit seg_cross(longint a1, longint b1, longint a2, longint b2,
                                     longint line, output longint b_out);
        longint den, num, db;
        logic [127:0] prod;
        logic [127:0] q;
        bit neg;
        b_out = 0;
        if ((a1 < line && a2 < line) || (a1 > line && a2 > line)) return 1'b0;
        den = a1 - a2;
        if (den == 0) return 1'b0;
        num = a1 - line;
        db = b2 - b1;
        prod = 128'(db < 0 ? -db : db) * 128'(num < 0 ? -num : num);
        q = prod / 128'(den < 0 ? -den : den);
        neg = (db < 0) ^ (num < 0) ^ (den < 0);
        b_out = neg ? b1 - longint'(q[63:0]) : b1 + longint'(q[63:0]);
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] to_q16(longint v);
        longint h;
        h = v >>> 1;
        if (h > 64'sh7FFFFFFF) h = 64'sh7FFFFFFF;
        if (h < -64'sh80000000) h = -64'sh80000000;
        return h[31:0];
    endfunction

    function automatic t_out_item predict_collision(t_in_item it);
        longint px, py, sw, sh, cx, cy, vx, vy, x1, x2, y1, y2, qx, qy, rx, ry, t;
        t_face face;
        t_out_item r;
        px = 2 * longint'(it.own_pos_x);
        py = 2 * longint'(it.own_pos_y);
        sw = longint'({1'b0, it.own_width}) + longint'({1'b0, it.other_width});
        sh = longint'({1'b0, it.own_height}) + longint'({1'b0, it.other_height});
        cx = 2 * longint'(it.other_pos_x);
        cy = 2 * longint'(it.other_pos_y);
        vx = 2 * (longint'(it.other_vel_x) - longint'(it.own_vel_x));
        vy = 2 * (longint'(it.other_vel_y) - longint'(it.own_vel_y));
        x1 = cx - sw; x2 = cx + sw; y1 = cy - sh; y2 = cy + sh;
        qx = px - vx; qy = py - vy;
        rx = 0; ry = 0; t = 0;
        face = FACE_NONE;
        if (px > x1 && px < x2 && py > y1 && py < y2) begin
            face = FACE_INSIDE; rx = px; ry = py;
        end else if (px < cx && seg_cross(px, py, qx, qy, x1, t) && t > y1 && t < y2) begin
            face = FACE_LEFT; rx = x1; ry = t;
        end else if (px > cx && seg_cross(px, py, qx, qy, x2, t) && t > y1 && t < y2) begin
            face = FACE_RIGHT; rx = x2; ry = t;
        end else if (py < cy && seg_cross(py, px, qy, qx, y1, t) && t > x1 && t < x2) begin
            face = FACE_BOTTOM; rx = t; ry = y1;
        end else if (py > cy && seg_cross(py, px, qy, qx, y2, t) && t > x1 && t < x2) begin
            face = FACE_TOP; rx = t; ry = y2;
        end
        r.hit = (face != FACE_NONE);
        r.hit_face = face;
        r.point_x = r.hit ? to_q16(rx) : '0;
        r.point_y = r.hit ? to_q16(ry) : '0;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic t_in_item rand_pair();
        t_in_item it;
        int mode;
        mode = $urandom_range(0, 5);
        if (mode > 2) mode = 1;
        it.own_pos_x   = rand_coord(mode);
        it.own_pos_y   = rand_coord(mode);
        it.own_vel_x   = rand_coord(mode);
        it.own_vel_y   = rand_coord(mode);
        it.other_pos_x = rand_coord(mode);
        it.other_pos_y = rand_coord(mode);
        it.other_vel_x = rand_coord(mode);
        it.other_vel_y = rand_coord(mode);
        if (mode == 0) begin
            it.own_width = 31'($urandom()); it.own_height = 31'($urandom());
            it.other_width = 31'($urandom()); it.other_height = 31'($urandom());
        end else begin
            it.own_width    = 31'($urandom_range(0, 300)) << 16;
            it.own_height   = 31'($urandom_range(0, 300)) << 16;
            it.other_width  = 31'($urandom_range(0, 300)) << 16;
            it.other_height = 31'($urandom_range(0, 300)) << 16;
        end
        if ($urandom_range(0, 7) == 0) it.other_vel_x = it.own_vel_x;
        if ($urandom_range(0, 7) == 0) it.other_vel_y = it.own_vel_y;
        return it;
    endfunction

    function automatic t_in_item make_pair(int px, int py, int ovx, int ovy, int ow, int oh,
                                           int cx, int cy, int cvx, int cvy, int cw, int ch);
        t_in_item it;
        it.own_pos_x = px << 16; it.own_pos_y = py << 16;
        it.own_vel_x = ovx << 16; it.own_vel_y = ovy << 16;
        it.own_width = 31'(ow << 16); it.own_height = 31'(oh << 16);
        it.other_pos_x = cx << 16; it.other_pos_y = cy << 16;
        it.other_vel_x = cvx << 16; it.other_vel_y = cvy << 16;
        it.other_width = 31'(cw << 16); it.other_height = 31'(ch << 16);
        return it;
    endfunction

    initial begin
        t_in_item it;
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 2, 2, 0, 0, 0, 0, 2, 2));
        pending_pairs.push_back(make_pair(-10, 0, 0, 0, 2, 2, 0, 0, 20, 0, 2, 2));
        pending_pairs.push_back(make_pair(10, 0, 0, 0, 2, 2, 0, 0, -20, 0, 2, 2));
        pending_pairs.push_back(make_pair(0, -10, 0, 0, 2, 2, 0, 0, 0, 20, 2, 2));
        pending_pairs.push_back(make_pair(0, 10, 0, 0, 2, 2, 0, 0, 0, -20, 2, 2));
        pending_pairs.push_back(make_pair(-10, 0, 0, 0, 2, 2, 0, 0, -20, 0, 2, 2));
        pending_pairs.push_back(make_pair(-2, 5, 0, 0, 2, 2, 0, 0, 0, 0, 2, 2));
        pending_pairs.push_back(make_pair(-2, 0, 0, 0, 2, 2, 0, 0, 0, 0, 2, 2));
        pending_pairs.push_back(make_pair(-10, 0, 0, 0, 2, 2, 0, 0, 20, 20, 2, 2));
        pending_pairs.push_back(make_pair(-10, 1, 3, 0, 0, 0, 0, 0, 17, 4, 0, 3));
        it = '0;
        pending_pairs.push_back(it);
        it = '1;
        pending_pairs.push_back(it);
        it.own_pos_x = 32'h80000000; it.own_pos_y = 32'h80000000;
        it.own_vel_x = 32'h7FFFFFFF; it.own_vel_y = 32'h7FFFFFFF;
        it.other_pos_x = 32'h7FFFFFFF; it.other_pos_y = 32'h7FFFFFFF;
        it.other_vel_x = 32'h80000000; it.other_vel_y = 32'h80000000;
        it.own_width = '1; it.own_height = '1; it.other_width = '1; it.other_height = '1;
        pending_pairs.push_back(it);
        it.own_width = '0; it.own_height = '0; it.other_width = '0; it.other_height = '0;
        pending_pairs.push_back(it);
        it.own_pos_x = 32'h7FFFFFFF; it.other_pos_x = 32'h80000000;
        it.own_vel_x = 32'h80000000; it.other_vel_x = 32'h7FFFFFFF;
        pending_pairs.push_back(it);
        for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(rand_pair());
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                expected_hits.push_back(predict_collision(req_if.data));
                n_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    src_gap <= $urandom_range(0, 2);
                    req_if.valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    req_if.data <= pending_pairs.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                res_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                snk_gap <= $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
            if (pending_pairs.size() < 100) calm <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, res_if.data);
            end else begin
                want = expected_hits.pop_front();
                n_checked++;
                if (want.hit_face < 6) face_count[want.hit_face]++;
                if (res_if.data.hit !== want.hit) begin
                    errors++;
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit,
                             res_if.data.hit);
                end
                if (res_if.data.hit_face !== want.hit_face) begin
                    errors++;
                    $display("%0t: hit_face expected %0d actual %0d", $time,
                             want.hit_face, res_if.data.hit_face);
                end
                if (res_if.data.point_x !== want.point_x) begin
                    errors++;
                    $display("%0t: point_x expected %h actual %h", $time, want.point_x,
                             res_if.data.point_x);
                end
                if (res_if.data.point_y !== want.point_y) begin
                    errors++;
                    $display("%0t: point_y expected %h actual %h", $time, want.point_y,
                             res_if.data.point_y);
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        while (!(pending_pairs.size() == 0 && !req_if.valid && expected_hits.size() == 0)
               && cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= LIMIT) begin
            $display("swept_point_box_collision_unit regression: fail");
            $finish;
        end else begin
            repeat (2 * LATENCY) @(posedge i_clk);
            $display("Checked %0d of %0d box pairs: %0d misses, %0d inside, %0d left,",
                     n_checked, n_sent, face_count[0], face_count[1], face_count[2]);
            $display("%0d right, %0d bottom, %0d top faces.", face_count[3],
                     face_count[4], face_count[5]);
            if (errors == 0 && expected_hits.size() == 0) begin
                $display("swept_point_box_collision_unit regression: pass");
            end else begin
                $display("swept_point_box_collision_unit regression: fail");
            end
            $finish;
        end
    end
endmodule
